// ===== hw/rtl/tcw_pkg.sv =====
// Shared types and constants for the text console cell writer.
// No dependencies; imported by tcw_put and the top level.
`default_nettype none

package tcw_pkg;

    localparam int REQ_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int ARG_W   = 8;
    localparam int CX_W    = 7;
    localparam int CY_W    = 6;
    localparam int GLYPH_W = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT    = 2'd0,
        REQ_SETCUR = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_READ   = 2'd3
    } t_req;

    localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
    localparam logic [CHAR_W-1:0] GLYPH_LOW  = 8'h20;
    localparam logic [CHAR_W-1:0] GLYPH_HIGH = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LC_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_GAP   = 8'd32;

    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'h20;

    // Outcome of one put-char request
    typedef struct packed {
        logic [CX_W-1:0]    x;
        logic [CY_W-1:0]    y;
        logic               scroll;
        logic               wr_en;
        logic [GLYPH_W-1:0] glyph;
    } t_put_res;

endpackage

`default_nettype wire

// ===== hw/rtl/tcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 4800
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_put.sv =====
// Put-char decode: control codes, glyph folding and cursor advance with wrap.
// Depends on tcw_pkg.
`default_nettype none

module tcw_put import tcw_pkg::*; #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 60
) (
    input  wire logic [CHAR_W-1:0] i_char,
    input  wire logic [CX_W-1:0]   i_cur_x,
    input  wire logic [CY_W-1:0]   i_cur_y,
    output t_put_res               o_res
);

    always_comb begin
        logic [CHAR_W-1:0] ch;
        logic              last_row;

        last_row     = (i_cur_y == CY_W'(SCREEN_ROWS - 1));
        o_res.x      = i_cur_x;
        o_res.y      = i_cur_y;
        o_res.scroll = 1'b0;
        o_res.wr_en  = 1'b0;
        o_res.glyph  = GLYPH_SPACE;

        ch = i_char;
        if (ch >= CH_LC_A && ch <= CH_LC_Z) begin
            ch = ch - CASE_GAP;
        end
        if (ch < GLYPH_LOW || ch > GLYPH_HIGH) begin
            ch = GLYPH_LOW;
        end

        priority if (i_char == CH_LF) begin
            o_res.x = '0;
            if (last_row) begin
                o_res.scroll = 1'b1;
            end else begin
                o_res.y = i_cur_y + 1'b1;
            end
        end else if (i_char == CH_CR) begin
            o_res.x = '0;
        end else if (i_char == CH_BS) begin
            if (i_cur_x != '0) begin
                o_res.x = i_cur_x - 1'b1;
            end
        end else begin
            o_res.wr_en = 1'b1;
            o_res.glyph = ch[GLYPH_W-1:0];
            // last column wraps as a line feed
            if (i_cur_x == CX_W'(SCREEN_COLS - 1)) begin
                o_res.x = '0;
                if (last_row) begin
                    o_res.scroll = 1'b1;
                end else begin
                    o_res.y = i_cur_y + 1'b1;
                end
            end else begin
                o_res.x = i_cur_x + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_cell_writer_top.sv =====
// Text console cell writer: one request word in, one result word out.
// Put char, set cursor and off-screen reads go straight to the done state, read cell first waits
// on the RAM read, and a scrolling put char or a clear first sweeps blank cells into the RAM.
// No new word is taken until the result of the last one is loaded into the output register.
// Scroll moves a row-offset register and blanks one row; clear sweeps the whole RAM.
// Reset: cursor homed, then a clearing pass over all SCREEN_COLS * SCREEN_ROWS cells (4800) with stall high.
`default_nettype none

module text_console_cell_writer_top import tcw_pkg::*; #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 60
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [REQ_W-1:0]   i_req_type,
    input  wire logic [CHAR_W-1:0]  i_char_code,
    input  wire logic [ARG_W-1:0]   i_col_arg,
    input  wire logic [ARG_W-1:0]   i_row_arg,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [CX_W-1:0]         o_cursor_x,
    output logic [CY_W-1:0]         o_cursor_y,
    output logic [GLYPH_W-1:0]      o_cell_glyph,
    output logic                    o_scrolled
);

    localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_SWEEP,
        ST_RDWAIT,
        ST_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [CX_W-1:0]     r_cur_x, n_cur_x;
    logic [CY_W-1:0]     r_cur_y, n_cur_y;
    logic [CY_W-1:0]     r_top, n_top;
    logic [ADDR_W-1:0]   r_sweep_addr, n_sweep_addr;
    logic [ADDR_W-1:0]   r_sweep_end, n_sweep_end;
    logic                r_res_scr, n_res_scr;
    logic [GLYPH_W-1:0]  r_res_glyph, n_res_glyph;
    logic                r_out_valid, n_out_valid;
    logic [CX_W-1:0]     r_out_x, n_out_x;
    logic [CY_W-1:0]     r_out_y, n_out_y;
    logic [GLYPH_W-1:0]  r_out_glyph, n_out_glyph;
    logic                r_out_scr, n_out_scr;

    logic                in_acc;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [GLYPH_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [GLYPH_W-1:0]  ram_rdata;
    logic [ADDR_W-1:0]   top_base;
    t_put_res            put;

    // logical row -> physical RAM address, rows rotate by the scroll offset
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [CY_W-1:0] row,
                                                    input logic [CX_W-1:0] col,
                                                    input logic [CY_W-1:0] top);
        logic [CY_W:0] sum;
        logic [CY_W:0] prow;
        sum  = {1'b0, row} + {1'b0, top};
        prow = (sum >= (CY_W+1)'(SCREEN_ROWS)) ? sum - (CY_W+1)'(SCREEN_ROWS) : sum;
        return ADDR_W'(prow) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col);
    endfunction

    tcw_put #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_put (
        .i_char  (i_char_code),
        .i_cur_x (r_cur_x),
        .i_cur_y (r_cur_y),
        .o_res   (put)
    );

    tcw_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_acc      = (r_state == ST_IDLE) && i_in_valid;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign top_base    = ADDR_W'(r_top) * ADDR_W'(SCREEN_COLS);
    assign o_out_valid = r_out_valid;
    assign o_cursor_x  = r_out_x;
    assign o_cursor_y  = r_out_y;
    assign o_cell_glyph = r_out_glyph;
    assign o_scrolled  = r_out_scr;

    always_comb begin
        n_state      = r_state;
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_top        = r_top;
        n_sweep_addr = r_sweep_addr;
        n_sweep_end  = r_sweep_end;
        n_res_scr    = r_res_scr;
        n_res_glyph  = r_res_glyph;
        n_out_valid  = r_out_valid;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_glyph  = r_out_glyph;
        n_out_scr    = r_out_scr;

        ram_we    = 1'b0;
        ram_waddr = r_sweep_addr;
        ram_wdata = GLYPH_SPACE;
        ram_re    = 1'b0;
        ram_raddr = cell_addr(i_row_arg[CY_W-1:0], i_col_arg[CX_W-1:0], r_top);

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLR: begin
                ram_we = 1'b1;
                if (r_sweep_addr == ADDR_W'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_sweep_addr = r_sweep_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_res_scr   = 1'b0;
                    n_res_glyph = '0;
                    n_state     = ST_DONE;
                    unique case (t_req'(i_req_type))
                        REQ_PUT: begin
                            ram_we    = put.wr_en;
                            ram_waddr = cell_addr(r_cur_y, r_cur_x, r_top);
                            ram_wdata = put.glyph;
                            n_cur_x   = put.x;
                            n_cur_y   = put.y;
                            n_res_scr = put.scroll;
                            if (put.scroll) begin
                                // old top row becomes the new bottom row; blank it
                                n_top = (r_top == CY_W'(SCREEN_ROWS - 1)) ? '0
                                                                          : r_top + 1'b1;
                                n_sweep_addr = top_base;
                                n_sweep_end  = top_base + ADDR_W'(SCREEN_COLS - 1);
                                n_state      = ST_SWEEP;
                            end
                        end
                        REQ_SETCUR: begin
                            if (i_col_arg < ARG_W'(SCREEN_COLS)) begin
                                n_cur_x = i_col_arg[CX_W-1:0];
                            end
                            if (i_row_arg < ARG_W'(SCREEN_ROWS)) begin
                                n_cur_y = i_row_arg[CY_W-1:0];
                            end
                        end
                        REQ_CLEAR: begin
                            n_cur_x      = '0;
                            n_cur_y      = '0;
                            n_top        = '0;
                            n_sweep_addr = '0;
                            n_sweep_end  = ADDR_W'(CELLS - 1);
                            n_state      = ST_SWEEP;
                        end
                        REQ_READ: begin
                            if (i_col_arg < ARG_W'(SCREEN_COLS) &&
                                i_row_arg < ARG_W'(SCREEN_ROWS)) begin
                                ram_re  = 1'b1;
                                n_state = ST_RDWAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                ram_we = 1'b1;
                if (r_sweep_addr == r_sweep_end) begin
                    n_state = ST_DONE;
                end else begin
                    n_sweep_addr = r_sweep_addr + 1'b1;
                end
            end
            ST_RDWAIT: begin
                n_res_glyph = ram_rdata;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_cur_x;
                    n_out_y     = r_cur_y;
                    n_out_glyph = r_res_glyph;
                    n_out_scr   = r_res_scr;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sweep_end <= n_sweep_end;
        r_res_scr   <= n_res_scr;
        r_res_glyph <= n_res_glyph;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_glyph <= n_out_glyph;
        r_out_scr   <= n_out_scr;
        if (!i_rst_n) begin
            r_state      <= ST_CLR;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_top        <= '0;
            r_sweep_addr <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cur_x      <= n_cur_x;
            r_cur_y      <= n_cur_y;
            r_top        <= n_top;
            r_sweep_addr <= n_sweep_addr;
            r_out_valid  <= n_out_valid;
        end
    end

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_x < (CX_W+1)'(SCREEN_COLS)) && (r_cur_y < (CY_W+1)'(SCREEN_ROWS)))
        else $error("cursor outside screen");

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top < (CY_W+1)'(SCREEN_ROWS))
        else $error("scroll offset outside screen");

    a_scroll_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_scr) |->
            (r_out_x == '0) && (r_out_y == CY_W'(SCREEN_ROWS - 1)))
        else $error("scrolled word with cursor off the bottom row start");

    a_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_CLR || r_state == ST_SWEEP || in_acc))
        else $error("screen write outside a sweep or an accepted word");

    a_read_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDWAIT) |=>
            (r_res_glyph >= GLYPH_LOW[GLYPH_W-1:0]) &&
            (r_res_glyph <= GLYPH_HIGH[GLYPH_W-1:0]))
        else $error("read glyph outside the printable set");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for text_console_cell_writer_top: directed and random console requests.
// Uses tcw_pkg and the top level only; a local screen model predicts every result word.
`timescale 1ns / 100ps

module tb;
    import tcw_pkg::*;

    localparam int COLS = 80;
    localparam int ROWS = 60;
    localparam int RANDOM_WORDS = 1200;
    localparam int CALM_TAIL = 150;

    typedef struct {
        t_req             kind;
        logic [CHAR_W-1:0] ch;
        logic [ARG_W-1:0]  col;
        logic [ARG_W-1:0]  row;
        bit                drain;
    } t_console_req;

    typedef struct packed {
        logic [CX_W-1:0]    cx;
        logic [CY_W-1:0]    cy;
        logic [GLYPH_W-1:0] glyph;
        logic               scr;
    } t_console_status;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [REQ_W-1:0]   i_req_type = '0;
    logic [CHAR_W-1:0]  i_char_code = '0;
    logic [ARG_W-1:0]   i_col_arg = '0;
    logic [ARG_W-1:0]   i_row_arg = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [CX_W-1:0]    o_cursor_x;
    logic [CY_W-1:0]    o_cursor_y;
    logic [GLYPH_W-1:0] o_cell_glyph;
    logic               o_scrolled;

    text_console_cell_writer_top #(
        .SCREEN_COLS(COLS),
        .SCREEN_ROWS(ROWS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_char_code (i_char_code),
        .i_col_arg   (i_col_arg),
        .i_row_arg   (i_row_arg),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cursor_x  (o_cursor_x),
        .o_cursor_y  (o_cursor_y),
        .o_cell_glyph(o_cell_glyph),
        .o_scrolled  (o_scrolled)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Screen model state
    logic [GLYPH_W-1:0] screen_copy [ROWS][COLS];
    int                 cur_col;
    int                 cur_row;

    t_console_req    request_backlog[$];
    t_console_status status_forecast[$];
    t_console_status status_seen[$];

    int   mismatches = 0;
    int   n_put = 0, n_setcur = 0, n_clear = 0, n_read = 0, n_scroll = 0;
    int   clears_left = 8;
    logic calm = 1'b0;
    logic [15:0] cycle_cnt = '0;

    function automatic void screen_blank();
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
                screen_copy[r][c] = GLYPH_SPACE;
        cur_col = 0;
        cur_row = 0;
    endfunction

    function automatic bit screen_newline();
        cur_col = 0;
        if (cur_row + 1 >= ROWS) begin
            for (int r = 0; r + 1 < ROWS; r++)
                for (int c = 0; c < COLS; c++)
                    screen_copy[r][c] = screen_copy[r + 1][c];
            for (int c = 0; c < COLS; c++)
                screen_copy[ROWS - 1][c] = GLYPH_SPACE;
            return 1'b1;
        end
        cur_row++;
        return 1'b0;
    endfunction

    function automatic bit screen_put(logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] g;
        if (ch == CH_LF)
            return screen_newline();
        if (ch == CH_CR) begin
            cur_col = 0;
            return 1'b0;
        end
        if (ch == CH_BS) begin
            if (cur_col > 0)
                cur_col--;
            return 1'b0;
        end
        g = ch;
        if (g >= CH_LC_A && g <= CH_LC_Z)
            g = g - CASE_GAP;
        if (g < GLYPH_LOW || g > GLYPH_HIGH)
            g = GLYPH_LOW;
        screen_copy[cur_row][cur_col] = g[GLYPH_W-1:0];
        cur_col++;
        if (cur_col >= COLS)
            return screen_newline();
        return 1'b0;
    endfunction

    function automatic t_console_status console_apply(t_console_req w);
        t_console_status s;
        s = '0;
        case (w.kind)
            REQ_PUT: begin
                s.scr = screen_put(w.ch);
                n_put++;
            end
            REQ_SETCUR: begin
                if (w.col < COLS)
                    cur_col = w.col;
                if (w.row < ROWS)
                    cur_row = w.row;
                n_setcur++;
            end
            REQ_CLEAR: begin
                screen_blank();
                n_clear++;
            end
            default: begin
                if (w.col < COLS && w.row < ROWS)
                    s.glyph = screen_copy[w.row][w.col];
                n_read++;
            end
        endcase
        if (s.scr)
            n_scroll++;
        s.cx = cur_col[CX_W-1:0];
        s.cy = cur_row[CY_W-1:0];
        return s;
    endfunction

    function automatic void queue_req(t_req kind, logic [CHAR_W-1:0] ch,
                                      logic [ARG_W-1:0] col, logic [ARG_W-1:0] row,
                                      bit drain = 1'b0);
        t_console_req w;
        w.kind  = kind;
        w.ch    = ch;
        w.col   = col;
        w.row   = row;
        w.drain = drain;
        request_backlog.push_back(w);
    endfunction

    // Coordinates biased toward the screen edges where wrap and scroll live
    function automatic logic [ARG_W-1:0] pick_coord(int span);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return ARG_W'($urandom_range(0, span - 1));
            6, 7:             return ARG_W'(span - 1 - $urandom_range(0, 1));
            default:          return ARG_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void queue_random(bit drain);
        logic [CHAR_W-1:0] ch;
        logic [ARG_W-1:0]  col, row;
        int                pick;
        ch   = CHAR_W'($urandom_range(0, 255));
        col  = ARG_W'($urandom_range(0, 255));
        row  = ARG_W'($urandom_range(0, 255));
        pick = $urandom_range(0, 119);
        if (pick == 0 && clears_left > 0) begin
            clears_left--;
            queue_req(REQ_CLEAR, ch, col, row, drain);
        end else if (pick < 72) begin
            case ($urandom_range(0, 19))
                0, 1, 2:  ch = CH_LF;
                3:        ch = CH_CR;
                4:        ch = CH_BS;
                5, 6, 7, 8, 9, 10, 11, 12: ch = CHAR_W'($urandom_range(8'h20, 8'h7F));
                default: ;
            endcase
            queue_req(REQ_PUT, ch, col, row, drain);
        end else if (pick < 88) begin
            queue_req(REQ_SETCUR, ch, pick_coord(COLS), pick_coord(ROWS), drain);
        end else begin
            if ($urandom_range(0, 4) != 0) begin
                col = ARG_W'($urandom_range(0, COLS - 1));
                row = ARG_W'($urandom_range(0, ROWS - 1));
            end
            queue_req(REQ_READ, ch, col, row, drain);
        end
    endfunction

    function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Driver: one word in flight, held steady while stalled
    t_console_req cur_req;
    int           gap_left = 0;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 16'd1;
        calm <= (request_backlog.size() < CALM_TAIL);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                status_forecast.push_back(console_apply(cur_req));
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (!calm && cycle_cnt[6] && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(0, 2);
                    i_in_valid <= 1'b0;
                end else if (request_backlog.size() > 0 &&
                             !(request_backlog[0].drain && status_forecast.size() > 0)) begin
                    cur_req = request_backlog.pop_front();
                    i_req_type  <= cur_req.kind;
                    i_char_code <= cur_req.ch;
                    i_col_arg   <= cur_req.col;
                    i_row_arg   <= cur_req.row;
                    i_in_valid  <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: sample on the rising edge, compare on the falling edge
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            status_seen.push_back({o_cursor_x, o_cursor_y, o_cell_glyph, o_scrolled});
        if (calm || !i_rst_n) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (cycle_cnt[7] && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        t_console_status got, want;
        if (status_seen.size() > 0) begin
            got = status_seen.pop_front();
            if (status_forecast.size() == 0) begin
                $display("%0t: result word with nothing expected: x %0d y %0d glyph %0d scr %0d",
                         $time, got.cx, got.cy, got.glyph, got.scr);
                mismatches++;
            end else begin
                want = status_forecast.pop_front();
                compare_field("cursor_x", 8'(want.cx), 8'(got.cx));
                compare_field("cursor_y", 8'(want.cy), 8'(got.cy));
                compare_field("cell_glyph", 8'(want.glyph), 8'(got.glyph));
                compare_field("scrolled", 8'(want.scr), 8'(got.scr));
            end
        end
    end

    initial begin
        screen_blank();

        // Directed: field extremes, case folding, controls, edges of the screen
        queue_req(REQ_READ, 8'hFF, 8'd0, 8'd0);
        queue_req(REQ_PUT, 8'h61, 8'hFF, 8'hFF);
        queue_req(REQ_PUT, CH_LC_Z, 8'h00, 8'h00);
        queue_req(REQ_PUT, 8'h00, 8'h00, 8'h00);
        queue_req(REQ_PUT, 8'hFF, 8'h00, 8'h00);
        queue_req(REQ_PUT, GLYPH_HIGH, 8'h00, 8'h00);
        queue_req(REQ_PUT, 8'h60, 8'h00, 8'h00);
        queue_req(REQ_PUT, 8'h80, 8'h00, 8'h00);
        queue_req(REQ_READ, 8'h00, 8'd0, 8'd0);
        queue_req(REQ_READ, 8'h00, 8'd1, 8'd0);
        queue_req(REQ_READ, 8'h00, 8'd4, 8'd0);
        queue_req(REQ_PUT, CH_BS, 8'h00, 8'h00);
        queue_req(REQ_PUT, CH_CR, 8'h00, 8'h00);
        queue_req(REQ_PUT, CH_BS, 8'hFF, 8'hFF);
        // reads outside the screen return zero
        queue_req(REQ_READ, 8'h00, 8'd255, 8'd255);
        queue_req(REQ_READ, 8'h00, 8'(COLS), 8'd0);
        queue_req(REQ_READ, 8'h00, 8'd0, 8'(ROWS));
        // last cell wraps and scrolls
        queue_req(REQ_SETCUR, 8'hFF, 8'(COLS - 1), 8'(ROWS - 1));
        queue_req(REQ_PUT, 8'h51, 8'h00, 8'h00);
        queue_req(REQ_READ, 8'h00, 8'(COLS - 1), 8'(ROWS - 2));
        queue_req(REQ_SETCUR, 8'h00, 8'd255, 8'd255);
        queue_req(REQ_SETCUR, 8'h00, 8'(COLS), 8'(ROWS - 1));
        queue_req(REQ_PUT, CH_LF, 8'h12, 8'h34);
        queue_req(REQ_SETCUR, 8'h00, 8'(COLS - 1), 8'd0);
        queue_req(REQ_PUT, 8'h41, 8'h00, 8'h00);
        queue_req(REQ_CLEAR, 8'hFF, 8'hFF, 8'hFF);
        queue_req(REQ_READ, 8'hFF, 8'd0, 8'(ROWS - 3));

        for (int i = 0; i < RANDOM_WORDS; i++)
            queue_random(i == 0 || i == RANDOM_WORDS / 2);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_backlog.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (status_forecast.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (status_forecast.size() != 0 || status_seen.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, status_forecast.size());
            mismatches++;
        end
        $display("Covered %0d requests: %0d put, %0d cursor set, %0d read, %0d clear.",
                 n_put + n_setcur + n_read + n_clear, n_put, n_setcur, n_read, n_clear);
        $display("Screen scrolled %0d times; %0d field mismatches.", n_scroll, mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #15000000;
        $display("%0t: timed out", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
